[src/bmns_pkg.sv]
// Shared types and constants of the bump map shading pipeline.
// No dependencies; imported by bmns_root_pipe and bumpmap_normal_shade_unit.
`default_nettype none

package bmns_pkg;

    localparam int HEIGHT_W    = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 22;

    localparam int LIGHT_W = 9;
    localparam int NZ2_W   = 22;
    localparam int NZLZ_W  = 19;
    localparam int LEVEL_W = 8;
    localparam int COMP_W  = 9;

    // gradient and dot product widths
    localparam int SUM3_W = HEIGHT_W + 2;
    localparam int GRAD_W = SUM3_W + 1;
    localparam int PROD_W = 20;
    localparam int DOT_W  = 21;
    localparam int NUM_W  = 20;
    localparam int DEN_W  = 23;

    // root division pipe
    localparam int ROOT_BITS = NUM_W;
    localparam int REM_W     = 2 * NUM_W;
    localparam int PART_W    = DEN_W + ROOT_BITS;
    localparam int TRIAL_W   = PART_W + ROOT_BITS + 1;

    // ambient fill
    localparam int SHADE_MAX   = 255;
    localparam int TERM_W      = 17;
    localparam int MIX_W       = TERM_W + LEVEL_W;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_255   = ((1 << RECIP_SHIFT) - 1) / SHADE_MAX;
    localparam int RECIP_W     = 17;
    localparam int EST_W       = MIX_W + RECIP_W;
    localparam int QUOT_W      = EST_W - RECIP_SHIFT;

    localparam int DEFAULT_FRACTION_BITS = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NZ_SQUARED = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NZ_LZ      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COMP       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_AMBIENT    = 3'd6;

    localparam logic signed [LIGHT_W-1:0] LIGHT_X_RESET    = -9'sd127;
    localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RESET    = 9'sd127;
    localparam logic [NZ2_W-1:0]          NZ_SQUARED_RESET = 22'd260100;
    localparam logic [NZLZ_W-1:0]         NZ_LZ_RESET      = 19'd91800;
    localparam logic [LEVEL_W-1:0]        BACKGROUND_RESET = 8'd180;
    localparam logic [COMP_W-1:0]         COMP_RESET       = 9'd181;
    localparam logic [LEVEL_W-1:0]        AMBIENT_RESET    = 8'd0;

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_FLAT,
        MODE_BACK,
        MODE_LIT
    } mode_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
    } pix_ctrl_t;

endpackage

`default_nettype wire

[src/bmns_root_pipe.sv]
// Pipelined floor(n / sqrt(d)): squares n, then one result bit per stage.
// Depends on bmns_pkg.
`default_nettype none

module bmns_root_pipe
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [bmns_pkg::NUM_W-1:0]   num,
    input  wire logic [bmns_pkg::DEN_W-1:0]   den,
    input  wire bmns_pkg::pix_ctrl_t          ctrl_in,
    output logic [bmns_pkg::ROOT_BITS-1:0]    root,
    output bmns_pkg::pix_ctrl_t               ctrl_out
);
    import bmns_pkg::*;

    // rem = n^2 - s^2*d, part = s*d
    logic [REM_W-1:0]     rem_reg  [ROOT_BITS];
    logic [PART_W-1:0]    part_reg [ROOT_BITS];
    logic [DEN_W-1:0]     den_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [ROOT_BITS+1];
    pix_ctrl_t            ctrl_reg [ROOT_BITS+1];

    logic [REM_W-1:0] num_sq;

    assign num_sq = REM_W'(num) * REM_W'(num);

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num_sq;
        part_reg[0] <= '0;
        den_reg[0]  <= den;
        root_reg[0] <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg[0] <= '0;
        end
        else
        begin
            ctrl_reg[0] <= ctrl_in;
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_stage
        localparam int B = ROOT_BITS - 1 - k;

        logic [TRIAL_W-1:0] trial;
        logic               fit;

        // (s + 2^B)^2 * d - s^2 * d = 2^(B+1) * s*d + 2^(2B) * d
        assign trial = (TRIAL_W'(part_reg[k]) << (B + 1))
                     + (TRIAL_W'(den_reg[k]) << (2 * B));
        assign fit   = trial <= TRIAL_W'(rem_reg[k]);

        always_ff @(posedge clk)
        begin
            root_reg[k+1] <= fit ? (root_reg[k] | (ROOT_BITS'(1) << B)) : root_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[k+1] <= '0;
            end
            else
            begin
                ctrl_reg[k+1] <= ctrl_reg[k];
            end
        end

        if (k < ROOT_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k+1]  <= fit ? (rem_reg[k] - REM_W'(trial)) : rem_reg[k];
                part_reg[k+1] <= fit ? (part_reg[k] + (PART_W'(den_reg[k]) << B))
                                     : part_reg[k];
                den_reg[k+1]  <= den_reg[k];
            end
        end
    end

    assign root     = root_reg[ROOT_BITS];
    assign ctrl_out = ctrl_reg[ROOT_BITS];

endmodule

`default_nettype wire

[src/bumpmap_normal_shade_unit.sv]
// Top level of the bump map Lambert shading pipeline.
// Depends on bmns_pkg and bmns_root_pipe.
`default_nettype none

// Usage:
//   Configuration: cfg_write with cfg_index and cfg_data writes one register at
//   the clock edge (0 light_x, 1 light_y, 2 nz squared, 3 nz*lz, 4 background,
//   5 compensation, 6 ambient). Other indexes are ignored. Write only while no
//   pixel is in flight.
//   Input: a pixel transaction is taken at every edge where start is high and
//   busy is low. busy is always low, so one pixel can enter on every clock.
//   Output: done is high for exactly one cycle with shade and paint valid. The
//   result of a pixel passes the front stages, the root divider and the back
//   stages, and results come out in input order.
//   Throughput: one pixel per clock. Depth is set by the root divider, one
//   squaring stage and 20 bit stages (one quotient bit per stage), plus three
//   front and four back stages.
//   Reset: clears every valid bit in the pipeline and loads the register
//   defaults; no result is produced until new pixels arrive.
//   Stalls: the receiver cannot hold results off, so the pipeline never stops.

module bumpmap_normal_shade_unit
#(
    parameter int FRACTION_BITS = bmns_pkg::DEFAULT_FRACTION_BITS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [bmns_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bmns_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [bmns_pkg::HEIGHT_W-1:0]     height_up_left,
    input  wire logic [bmns_pkg::HEIGHT_W-1:0]     height_up_mid,
    input  wire logic [bmns_pkg::HEIGHT_W-1:0]     height_up_right,
    input  wire logic [bmns_pkg::HEIGHT_W-1:0]     height_mid_left,
    input  wire logic [bmns_pkg::HEIGHT_W-1:0]     height_mid_right,
    input  wire logic [bmns_pkg::HEIGHT_W-1:0]     height_down_left,
    input  wire logic [bmns_pkg::HEIGHT_W-1:0]     height_down_mid,
    input  wire logic [bmns_pkg::HEIGHT_W-1:0]     height_down_right,
    input  wire logic                              inside_map,
    input  wire logic                              selected,
    output logic                                   done,
    output logic [bmns_pkg::LEVEL_W-1:0]           shade,
    output logic                                   paint
);
    import bmns_pkg::*;

    localparam int SCALED_W = ROOT_BITS + FRACTION_BITS;

    // configuration registers
    logic signed [LIGHT_W-1:0] lx_reg;
    logic signed [LIGHT_W-1:0] ly_reg;
    logic [NZ2_W-1:0]          nz2_reg;
    logic [NZLZ_W-1:0]         nzlz_reg;
    logic [LEVEL_W-1:0]        bg_reg;
    logic [COMP_W-1:0]         comp_reg;
    logic [LEVEL_W-1:0]        amb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg   <= LIGHT_X_RESET;
            ly_reg   <= LIGHT_Y_RESET;
            nz2_reg  <= NZ_SQUARED_RESET;
            nzlz_reg <= NZ_LZ_RESET;
            bg_reg   <= BACKGROUND_RESET;
            comp_reg <= COMP_RESET;
            amb_reg  <= AMBIENT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LIGHT_X:    lx_reg   <= $signed(cfg_data[LIGHT_W-1:0]);
                REG_LIGHT_Y:    ly_reg   <= $signed(cfg_data[LIGHT_W-1:0]);
                REG_NZ_SQUARED: nz2_reg  <= cfg_data[NZ2_W-1:0];
                REG_NZ_LZ:      nzlz_reg <= cfg_data[NZLZ_W-1:0];
                REG_BACKGROUND: bg_reg   <= cfg_data[LEVEL_W-1:0];
                REG_COMP:       comp_reg <= cfg_data[COMP_W-1:0];
                REG_AMBIENT:    amb_reg  <= cfg_data[LEVEL_W-1:0];
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- stage 1: gradient ----------------
    logic [SUM3_W-1:0]        sum_left, sum_right, sum_up, sum_down;
    logic signed [GRAD_W-1:0] nx_next, ny_next;
    pix_ctrl_t                c1_next;
    logic signed [GRAD_W-1:0] nx_reg, ny_reg;
    pix_ctrl_t                c1_reg;

    assign sum_left  = SUM3_W'(height_up_left) + SUM3_W'(height_mid_left)
                     + SUM3_W'(height_down_left);
    assign sum_right = SUM3_W'(height_up_right) + SUM3_W'(height_mid_right)
                     + SUM3_W'(height_down_right);
    assign sum_up    = SUM3_W'(height_up_left) + SUM3_W'(height_up_mid)
                     + SUM3_W'(height_up_right);
    assign sum_down  = SUM3_W'(height_down_left) + SUM3_W'(height_down_mid)
                     + SUM3_W'(height_down_right);
    assign nx_next   = $signed(GRAD_W'(sum_left)) - $signed(GRAD_W'(sum_right));
    assign ny_next   = $signed(GRAD_W'(sum_down)) - $signed(GRAD_W'(sum_up));

    always_comb
    begin
        c1_next.valid = start;
        priority if (!selected)
            c1_next.mode = MODE_OFF;
        else if (!inside_map || (nx_next == '0 && ny_next == '0))
            c1_next.mode = MODE_FLAT;
        else
            c1_next.mode = MODE_LIT;
    end

    always_ff @(posedge clk)
    begin
        nx_reg <= nx_next;
        ny_reg <= ny_next;
    end

    // ---------------- stage 2: products ----------------
    logic signed [PROD_W-1:0] nx_ext, ny_ext, lx_ext, ly_ext;
    logic signed [PROD_W-1:0] pxl_reg, pyl_reg;
    logic [PROD_W-1:0]        sqx_reg, sqy_reg;
    pix_ctrl_t                c2_reg;

    assign nx_ext = PROD_W'(nx_reg);
    assign ny_ext = PROD_W'(ny_reg);
    assign lx_ext = PROD_W'(lx_reg);
    assign ly_ext = PROD_W'(ly_reg);

    always_ff @(posedge clk)
    begin
        pxl_reg <= nx_ext * lx_ext;
        pyl_reg <= ny_ext * ly_ext;
        sqx_reg <= nx_ext * nx_ext;
        sqy_reg <= ny_ext * ny_ext;
    end

    // ---------------- stage 3: dot product and norm ----------------
    logic signed [DOT_W-1:0] dot;
    logic [DEN_W-1:0]        den_next;
    pix_ctrl_t               c3_next;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        den_reg;
    pix_ctrl_t               c3_reg;

    assign dot      = DOT_W'(pxl_reg) + DOT_W'(pyl_reg) + $signed(DOT_W'(nzlz_reg));
    assign den_next = DEN_W'(sqx_reg) + DEN_W'(sqy_reg) + DEN_W'(nz2_reg);

    always_comb
    begin
        c3_next = c2_reg;
        if (c2_reg.mode == MODE_LIT && dot[DOT_W-1])
            c3_next.mode = MODE_BACK;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= dot[DOT_W-1] ? '0 : dot[NUM_W-1:0];
        den_reg <= den_next;
    end

    // ---------------- root divider ----------------
    logic [ROOT_BITS-1:0] root;
    pix_ctrl_t            cr;

    bmns_root_pipe u_root
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .num      (num_reg),
        .den      (den_reg),
        .ctrl_in  (c3_reg),
        .root     (root),
        .ctrl_out (cr)
    );

    // ---------------- stage A: base shade and fill term ----------------
    logic [SCALED_W-1:0] scaled;
    logic [TERM_W-1:0]   cap;
    logic [TERM_W-1:0]   back_prod;
    logic [TERM_W-1:0]   back_val;
    logic [LEVEL_W-1:0]  base_next;
    logic [TERM_W-1:0]   term_next;
    logic [TERM_W-1:0]   term_reg;
    logic [LEVEL_W-1:0]  base_a_reg;
    pix_ctrl_t           ca_reg;

    assign scaled    = SCALED_W'(root) << FRACTION_BITS;
    assign cap       = TERM_W'(comp_reg) * TERM_W'(SHADE_MAX);
    assign back_prod = TERM_W'(comp_reg) * TERM_W'(amb_reg);
    assign back_val  = back_prod >> FRACTION_BITS;

    always_comb
    begin
        term_next = '0;
        unique case (cr.mode)
            MODE_OFF:  base_next = '0;
            MODE_FLAT: base_next = bg_reg;
            MODE_BACK: base_next = (back_val > TERM_W'(SHADE_MAX)) ? LEVEL_W'(SHADE_MAX)
                                                                   : back_val[LEVEL_W-1:0];
            MODE_LIT:
            begin
                base_next = (root > ROOT_BITS'(SHADE_MAX)) ? LEVEL_W'(SHADE_MAX)
                                                           : root[LEVEL_W-1:0];
                if (scaled < SCALED_W'(cap))
                    term_next = cap - TERM_W'(scaled);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        term_reg   <= term_next;
        base_a_reg <= base_next;
    end

    // ---------------- stage B: fill product ----------------
    logic [MIX_W-1:0]   mix_reg;
    logic [LEVEL_W-1:0] base_b_reg;
    pix_ctrl_t          cb_reg;

    always_ff @(posedge clk)
    begin
        mix_reg    <= MIX_W'(term_reg) * MIX_W'(amb_reg);
        base_b_reg <= base_a_reg;
    end

    // ---------------- stage C: divide by 255, estimate ----------------
    // reciprocal is (2^24-1)/255, so the estimate is exact or one low
    logic [MIX_W-1:0]   frac_val;
    logic [EST_W-1:0]   est_full;
    logic [MIX_W-1:0]   x_reg;
    logic [QUOT_W-1:0]  q0_reg;
    logic [LEVEL_W-1:0] base_c_reg;
    pix_ctrl_t          cc_reg;

    assign frac_val = mix_reg >> FRACTION_BITS;
    assign est_full = EST_W'(frac_val) * EST_W'(RECIP_255);

    always_ff @(posedge clk)
    begin
        x_reg      <= frac_val;
        q0_reg     <= est_full[EST_W-1:RECIP_SHIFT];
        base_c_reg <= base_b_reg;
    end

    // ---------------- stage D: correct, add, saturate ----------------
    logic [MIX_W-1:0]    rest;
    logic [QUOT_W-1:0]   quot;
    logic [QUOT_W:0]     total;
    logic [LEVEL_W-1:0]  shade_next;
    logic                done_reg;
    logic [LEVEL_W-1:0]  shade_reg;
    logic                paint_reg;

    assign rest  = x_reg - MIX_W'(q0_reg) * MIX_W'(SHADE_MAX);
    assign quot  = q0_reg + QUOT_W'(rest >= MIX_W'(SHADE_MAX));
    assign total = (QUOT_W+1)'(base_c_reg) + (QUOT_W+1)'(quot);
    assign shade_next = (total > (QUOT_W+1)'(SHADE_MAX)) ? LEVEL_W'(SHADE_MAX)
                                                         : total[LEVEL_W-1:0];

    always_ff @(posedge clk)
    begin
        shade_reg <= shade_next;
        paint_reg <= (cc_reg.mode != MODE_OFF);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg   <= '0;
            c2_reg   <= '0;
            c3_reg   <= '0;
            ca_reg   <= '0;
            cb_reg   <= '0;
            cc_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            c1_reg   <= c1_next;
            c2_reg   <= c1_reg;
            c3_reg   <= c3_next;
            ca_reg   <= cr;
            cb_reg   <= ca_reg;
            cc_reg   <= cb_reg;
            done_reg <= cc_reg.valid;
        end
    end

    assign done  = done_reg;
    assign shade = shade_reg;
    assign paint = paint_reg;

endmodule

`default_nettype wire
